// ===== hw/rtl/rc4s_pkg.sv =====
`default_nettype none

package rc4s_pkg;

  localparam int unsigned KEY_MAX    = 64;
  localparam int unsigned KCNT_W     = $clog2(KEY_MAX + 1);
  localparam int unsigned KIDX_W     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned SBOX_DEPTH = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  clr;
    logic  rd_en;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
  } sbox_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4s_sbox.sv =====
`default_nettype none

module rc4s_sbox (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rc4s_pkg::sbox_req_t req,
  output      rc4s_pkg::byte_t    rd_data
);
  import rc4s_pkg::*;

  byte_t                 mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_r;
  byte_t                 mem_q_r;
  byte_t                 addr_q_r;
  logic                  vld_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r  <= mem[req.rd_addr];
      addr_q_r <= req.rd_addr;
    end
  end

  // entry not yet written since reset or the last clear reads as identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : addr_q_r;

  a_clr_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.clr && (req.wr_en || req.rd_en)))
    else $error("sbox clear overlaps an access");

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher engine, one byte per transaction.
// Input channel: in_tuser selects key byte (0) or data byte (1), in_tdata
// carries the byte, in_tlast marks the final key byte or final data byte.
// Key bytes are collected (up to KEY_MAX, extra ones dropped); the key byte
// with in_tlast set starts the key schedule, which walks all 256 state
// entries, each through states ST_K0 to ST_K3; in_tready is low until it
// ends. Key bytes produce no output. A new byte is taken only in ST_IDLE.
// Each data byte goes through these steps: read S[i], read S[j], write S[i]
// and read the keystream entry, write S[j]. The state RAM has a read port
// and a write port. The result enters the output register together with
// the write of S[j], carrying in_tlast through to out_tlast.
// The output register holds its transaction while out_tready is low; a new
// input is still taken, but it waits in its last step until the register
// frees up.
// Reset restores the identity permutation at once (per-entry valid flags),
// clears both indices and any partial key. No clearing pass is needed.
`default_nettype none

module rc4_stream_cipher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire rc4s_pkg::byte_t     in_tdata,   // [7:0] byte_in
  input  wire logic                in_tuser,   // [0] operation
  input  wire logic                in_tlast,
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  output      rc4s_pkg::byte_t     out_tdata,  // [7:0] byte_out
  output      logic                out_tlast
);
  import rc4s_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_D1   = 8'b0000_0010,
    ST_D2   = 8'b0000_0100,
    ST_D3   = 8'b0000_1000,
    ST_K0   = 8'b0001_0000,
    ST_K1   = 8'b0010_0000,
    ST_K2   = 8'b0100_0000,
    ST_K3   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  byte_t             i_r, i_nxt;
  byte_t             j_r, j_nxt;
  byte_t             si_r, si_nxt;
  byte_t             sj_r, sj_nxt;
  logic              hit_i_r, hit_i_nxt;
  logic              hit_j_r, hit_j_nxt;
  byte_t             byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [KCNT_W-1:0] cnt_r, cnt_nxt;
  logic [KCNT_W-1:0] kidx_r, kidx_nxt;
  logic              loading_r, loading_nxt;
  logic              out_valid_r, out_valid_nxt;
  byte_t             out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  byte_t             key_mem [KEY_MAX];
  byte_t             key_q_r;
  logic              key_wr_en;
  logic              key_rd_en;

  sbox_req_t         sb_req;
  byte_t             sb_rd;

  logic              accept;
  logic              out_free;
  logic [KCNT_W-1:0] key_base;
  logic              key_room;
  logic [KCNT_W-1:0] kidx_inc;
  byte_t             ks_addr;
  byte_t             ks;
  byte_t             j_data;
  byte_t             j_sched;

  rc4s_sbox u_sbox (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sb_req),
    .rd_data (sb_rd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign key_base   = loading_r ? cnt_r : '0;
  assign key_room   = key_base < KCNT_W'(KEY_MAX);
  assign kidx_inc   = kidx_r + KCNT_W'(1);
  assign ks_addr    = si_r + sb_rd;
  assign ks         = hit_j_r ? si_r : (hit_i_r ? sj_r : sb_rd);
  assign j_data     = j_r + sb_rd;
  assign j_sched    = j_r + sb_rd + key_q_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    hit_i_nxt     = hit_i_r;
    hit_j_nxt     = hit_j_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    loading_nxt   = loading_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    key_wr_en     = 1'b0;
    key_rd_en     = 1'b0;
    sb_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_DATA) begin
            i_nxt          = i_r + 8'd1;
            sb_req.rd_en   = 1'b1;
            sb_req.rd_addr = i_r + 8'd1;
            byte_nxt       = in_tdata;
            last_nxt       = in_tlast;
            state_nxt      = ST_D1;
          end else begin
            loading_nxt = 1'b1;
            if (key_room) begin
              key_wr_en = 1'b1;
              cnt_nxt   = key_base + KCNT_W'(1);
            end else begin
              cnt_nxt   = key_base;
            end
            if (in_tlast) begin
              sb_req.clr = 1'b1;
              i_nxt      = '0;
              j_nxt      = '0;
              kidx_nxt   = '0;
              state_nxt  = ST_K0;
            end
          end
        end
      end
      ST_D1: begin
        si_nxt         = sb_rd;
        j_nxt          = j_data;
        sb_req.rd_en   = 1'b1;
        sb_req.rd_addr = j_data;
        state_nxt      = ST_D2;
      end
      ST_D2: begin
        sb_req.wr_en   = 1'b1;
        sb_req.wr_addr = i_r;
        sb_req.wr_data = sb_rd;
        sj_nxt         = sb_rd;
        sb_req.rd_en   = 1'b1;
        sb_req.rd_addr = ks_addr;
        hit_i_nxt      = (ks_addr == i_r);
        hit_j_nxt      = (ks_addr == j_r);
        state_nxt      = ST_D3;
      end
      ST_D3: begin
        if (out_free) begin
          sb_req.wr_en   = 1'b1;
          sb_req.wr_addr = j_r;
          sb_req.wr_data = si_r;
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = byte_r ^ ks;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_K0: begin
        sb_req.rd_en   = 1'b1;
        sb_req.rd_addr = i_r;
        key_rd_en      = 1'b1;
        state_nxt      = ST_K1;
      end
      ST_K1: begin
        si_nxt         = sb_rd;
        j_nxt          = j_sched;
        sb_req.rd_en   = 1'b1;
        sb_req.rd_addr = j_sched;
        state_nxt      = ST_K2;
      end
      ST_K2: begin
        sb_req.wr_en   = 1'b1;
        sb_req.wr_addr = i_r;
        sb_req.wr_data = sb_rd;
        state_nxt      = ST_K3;
      end
      ST_K3: begin
        sb_req.wr_en   = 1'b1;
        sb_req.wr_addr = j_r;
        sb_req.wr_data = si_r;
        i_nxt          = i_r + 8'd1;
        kidx_nxt       = (kidx_inc == cnt_r) ? '0 : kidx_inc;
        if (i_r == 8'hFF) begin
          j_nxt       = '0;
          loading_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt   = ST_K0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      kidx_r      <= '0;
      loading_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      kidx_r      <= kidx_nxt;
      loading_r   <= loading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    hit_i_r    <= hit_i_nxt;
    hit_j_r    <= hit_j_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_base[KIDX_W-1:0]] <= in_tdata;
    end
    if (key_rd_en) begin
      key_q_r <= key_mem[kidx_r[KIDX_W-1:0]];
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K3 && i_r == 8'hFF) |=>
      (state_r == ST_IDLE && i_r == 8'd0 && j_r == 8'd0 && !loading_r))
    else $error("key schedule did not leave indices cleared");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D3 && out_free) |=> out_valid_r)
    else $error("data result not loaded into output register");

  a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KCNT_W'(KEY_MAX))
    else $error("key count beyond key store depth");

  a_key_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K0) |-> (kidx_r < cnt_r))
    else $error("key index outside loaded key");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rc4s_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned TAIL_START  = 1300;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned SETTLE      = 1100;

  typedef struct packed {
    byte_t data;
    logic  last;
  } cipher_res_t;

  typedef struct packed {
    logic  op;
    byte_t data;
    logic  last;
    logic  fixed;
    byte_t want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_tvalid = 1'b0;
  logic  in_tready;
  byte_t in_tdata = '0;
  logic  in_tuser = OP_KEY;
  logic  in_tlast = 1'b0;
  logic  out_tvalid;
  logic  out_tready = 1'b0;
  byte_t out_tdata;
  logic  out_tlast;

  rc4_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  byte_t       sbox [SBOX_DEPTH];
  byte_t       key_bytes [KEY_MAX];
  int unsigned key_len;
  byte_t       idx_i;
  byte_t       idx_j;
  bit          key_open;

  cipher_res_t cipher_q [$];
  cipher_res_t want_r;
  int unsigned items_sent;
  int unsigned data_sent;
  int unsigned schedules;
  int unsigned long_keys;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned cycle_cnt;
  bit          hold_req;

  stim_row_t dir_tab [0:13] = '{
    '{OP_DATA, 8'h00, 1'b0, 1'b1, 8'h02},  // data before any key
    '{OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA},
    '{OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00},  // one-byte key
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{OP_KEY,  8'h80, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h55, 1'b0, 1'b0, 8'h00},  // data mid key load
    '{OP_KEY,  8'h01, 1'b1, 1'b0, 8'h00},
    '{OP_DATA, 8'hAA, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h00, 1'b1, 1'b0, 8'h00},
    '{OP_KEY,  8'h7F, 1'b1, 1'b0, 8'h00},
    '{OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h80, 1'b1, 1'b0, 8'h00}
  };

  function automatic void sbox_identity();
    for (int k = 0; k < SBOX_DEPTH; k++) begin
      sbox[k] = byte_t'(k);
    end
  endfunction

  function automatic void run_key_schedule();
    byte_t jj;
    byte_t t;
    jj = '0;
    sbox_identity();
    for (int k = 0; k < SBOX_DEPTH; k++) begin
      jj = jj + sbox[k] + key_bytes[k % key_len];
      t = sbox[k];
      sbox[k] = sbox[jj];
      sbox[jj] = t;
    end
    idx_i = '0;
    idx_j = '0;
    key_open = 1'b0;
  endfunction

  // returns 1 when the transaction yields a ciphered byte
  function automatic bit rc4_predict(input logic op, input byte_t b, input logic lst,
                                     output cipher_res_t r);
    byte_t t;
    byte_t sum;
    r = '0;
    if (op == OP_KEY) begin
      if (!key_open) begin
        key_len = 0;
        key_open = 1'b1;
      end
      if (key_len < KEY_MAX) begin
        key_bytes[key_len] = b;
        key_len++;
      end else if (lst) begin
        long_keys++;
      end
      if (lst) begin
        run_key_schedule();
        schedules++;
      end
      return 1'b0;
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    sum = sbox[idx_i] + sbox[idx_j];
    r.data = b ^ sbox[sum];
    r.last = lst;
    return 1'b1;
  endfunction

  function automatic bit idle_allowed();
    return (items_sent < TAIL_START) && (((items_sent / 97) % 4) != 3);
  endfunction

  task automatic send_item(input logic op, input byte_t b, input logic lst,
                           input logic fixed, input byte_t want);
    cipher_res_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_DATA) data_sent++;
    if (rc4_predict(op, b, lst, r)) begin
      if (fixed) r.data = want;
      cipher_q.push_back(r);
    end
    if (idle_allowed() && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 5) begin
        send_item(OP_DATA, byte_t'($urandom), 1'b0, 1'b0, '0);
      end
      send_item(OP_KEY, byte_t'($urandom), k == len - 1, 1'b0, '0);
    end
  endtask

  task automatic send_data(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_item(OP_DATA, byte_t'($urandom),
                (k == len - 1) || ($urandom_range(0, 99) < 10), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results outstanding", $time, cipher_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got data=%02h last=%b",
                 $time, out_tdata, out_tlast);
      end else begin
        want_r = cipher_q.pop_front();
        if (out_tdata !== want_r.data) begin
          errors++;
          $display("%0t: byte_out mismatch, expected %02h, got %02h",
                   $time, want_r.data, out_tdata);
        end
        if (out_tlast !== want_r.last) begin
          errors++;
          $display("%0t: last_out mismatch, expected %b, got %b",
                   $time, want_r.last, out_tlast);
        end
      end
    end
  end

  // receiver side
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_allowed() && $urandom_range(0, 99) < 15) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    bit hold_done;
    bit pause_done;
    int unsigned pick;
    int unsigned groups;
    sbox_identity();
    key_len = 0;
    idx_i = '0;
    idx_j = '0;
    key_open = 1'b0;
    cycle_cnt = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    groups = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[n]) begin
      send_item(dir_tab[n].op, dir_tab[n].data, dir_tab[n].last,
                dir_tab[n].fixed, dir_tab[n].want);
    end
    in_tvalid <= 1'b0;
    wait (cipher_q.size() == 0);

    while (items_sent < ITEM_TARGET) begin
      if (!pause_done && items_sent >= 800) begin
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (cipher_q.size() == 0);
      end
      if (!hold_done && items_sent >= 400) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
        send_data(30);
        continue;
      end
      pick = $urandom_range(0, 99);
      if (groups == 0) begin
        send_key(70);  // over-long key, final mark on a dropped byte
        send_data($urandom_range(1, 40));
      end else if (pick < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send_key($urandom_range(1, 16));
        else if (pick < 92) send_key($urandom_range(17, KEY_MAX));
        else send_key($urandom_range(KEY_MAX + 1, KEY_MAX + 8));
        send_data($urandom_range(1, 40));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(logic'($urandom_range(0, 1)), byte_t'($urandom),
                    logic'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
      groups++;
    end
    in_tvalid <= 1'b0;

    wait (cipher_q.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d transactions (%0d data bytes), checked %0d ciphered bytes.",
             items_sent, data_sent, results_seen);
    $display("Ran %0d key schedules, %0d of them from keys longer than %0d bytes.",
             schedules, long_keys, KEY_MAX);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rc4s_pkg.sv
hw/rtl/rc4s_sbox.sv
hw/rtl/rc4_stream_cipher.sv
tb/tb_top.sv
